@@ rtl/ukf_pkg.sv @@
// Package for the unique-key FIFO: sizes, status and command codes,
// and the control word that drives the row of storage cells.
// No dependencies.
package ukf_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned OccW         = 5;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef struct packed {
    logic shift;  // dequeue: every cell takes its right neighbour
    logic enq;    // enqueue: first empty cell loads the new pair
  } cell_ctrl_t;

endpackage

@@ rtl/ukf_cell.sv @@
// One storage cell of the unique-key FIFO: holds a key/value pair and a
// valid flag, compares its key against the search key each cycle.
// Depends on ukf_pkg.
module ukf_cell import ukf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             left_valid_i,
  input  logic             nxt_valid_i,
  input  logic [DataW-1:0] nxt_key_i,
  input  logic [DataW-1:0] nxt_value_i,
  input  logic [DataW-1:0] new_key_i,
  input  logic [DataW-1:0] new_value_i,
  output logic             valid_o,
  output logic [DataW-1:0] key_o,
  output logic [DataW-1:0] value_o,
  output logic             hit_o
);

  logic             valid_q;
  logic [DataW-1:0] key_q;
  logic [DataW-1:0] value_q;
  logic             hit_q;
  logic             load;

  // first empty slot of the row: left neighbour full, this one empty
  assign load = ctrl_i.enq && !valid_q && left_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= nxt_valid_i;
    end else if (load) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q   <= nxt_key_i;
      value_q <= nxt_value_i;
    end else if (load) begin
      key_q   <= new_key_i;
      value_q <= new_value_i;
    end
    hit_q <= valid_q && (key_q == new_key_i);
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

@@ rtl/unique_key_fifo.sv @@
// Top level of the unique-key FIFO: transaction control, occupancy count,
// result register and the row of ukf_cell storage cells.
// Depends on ukf_pkg and ukf_cell.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   in       | in_valid_i / in_ready_o | cmd_i, key_i, value_i
//   out      | out_valid_o/out_ready_i | status_o, out_key_o, out_value_o,
//            |                         | occupancy_o
//
// Each transaction passes through accept, per-cell key compare (registered),
// then OR of the cell hits, decision and cell update; the head is cell 0.
// One transaction in flight; the next is accepted once the update is done.
// The update waits while the result register is still held by the consumer.
// Reset empties the queue at once by clearing the cell valid flags.
module unique_key_fifo import ukf_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic signed [DataW-1:0]   key_i,
  input  logic signed [DataW-1:0]   value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic        [StatusW-1:0] status_o,
  output logic signed [DataW-1:0]   out_key_o,
  output logic signed [DataW-1:0]   out_value_o,
  output logic        [OccW-1:0]    occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  cmd_e             op_cmd_q;
  logic [DataW-1:0] op_key_q;
  logic [DataW-1:0] op_value_q;

  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [DataW-1:0] okey_q, okey_d;
  logic [DataW-1:0] oval_q, oval_d;
  logic [OccW-1:0]  occ_q;

  logic             in_acc;
  logic             upd_go;
  logic             dup;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;

  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_hit;
  logic [DataW-1:0] cell_key   [DEPTH];
  logic [DataW-1:0] cell_value [DEPTH];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign upd_go     = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  assign dup   = |cell_hit;
  assign full  = (cnt_q == CntW'(DEPTH));
  assign empty = (cnt_q == '0);

  assign ctrl.enq   = upd_go && (op_cmd_q == CMD_ENQ) && !dup && !full;
  assign ctrl.shift = upd_go && (op_cmd_q == CMD_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             left_valid;
    logic             nxt_valid;
    logic [DataW-1:0] nxt_key;
    logic [DataW-1:0] nxt_value;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
    end else begin : g_inner
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nxt_valid = 1'b0;
      assign nxt_key   = '0;
      assign nxt_value = '0;
    end else begin : g_mid
      assign nxt_valid = cell_valid[i+1];
      assign nxt_key   = cell_key[i+1];
      assign nxt_value = cell_value[i+1];
    end

    ukf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_valid_i (left_valid),
      .nxt_valid_i  (nxt_valid),
      .nxt_key_i    (nxt_key),
      .nxt_value_i  (nxt_value),
      .new_key_i    (op_key_q),
      .new_value_i  (op_value_q),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .hit_o        (cell_hit[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  if (upd_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    status_d = ST_ENQUEUED;
    okey_d   = '0;
    oval_d   = '0;
    if (op_cmd_q == CMD_ENQ) begin
      if (dup) begin
        status_d = ST_DUPLICATE;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_ENQUEUED;
        cnt_d    = cnt_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_REMOVED;
        okey_d   = cell_key[0];
        oval_d   = cell_value[0];
        cnt_d    = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_go) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_cmd_q   <= cmd_e'(cmd_i);
      op_key_q   <= key_i;
      op_value_q <= value_i;
    end
    if (upd_go) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      oval_q   <= oval_d;
      occ_q    <= OccW'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_key_o   = okey_q;
  assign out_value_o = oval_q;
  assign occupancy_o = occ_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("occupancy count exceeds depth");

  a_cells_match_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(cnt_q))
    else $error("cell valid flags disagree with count");

  a_upd_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) && out_valid_q && !out_ready_i |=> (state_q == S_UPD))
    else $error("update committed while result register held");

  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CMP))
    else $error("accepted transaction did not enter compare");
`endif

endmodule
